// ===== rtl/hscc_pkg.sv =====
`timescale 1ns / 1ps
package hscc_pkg;

    localparam int CHR_W  = 21;
    localparam int CLS_W  = 4;
    localparam int PEEK_N = 9;

    typedef logic [CHR_W-1:0] t_chr;

    // style classes
    localparam logic [CLS_W-1:0] CLS_PLAIN   = 4'd0;
    localparam logic [CLS_W-1:0] CLS_PREPROC = 4'd1;
    localparam logic [CLS_W-1:0] CLS_COMMENT = 4'd2;
    localparam logic [CLS_W-1:0] CLS_ENTITY  = 4'd3;
    localparam logic [CLS_W-1:0] CLS_STRING  = 4'd4;
    localparam logic [CLS_W-1:0] CLS_TAG     = 4'd5;
    localparam logic [CLS_W-1:0] CLS_PHP     = 4'd6;
    localparam logic [CLS_W-1:0] CLS_ASP     = 4'd7;
    localparam logic [CLS_W-1:0] CLS_SCRIPT  = 4'd8;
    localparam logic [CLS_W-1:0] CLS_STYLE   = 4'd9;

    // entity kinds
    localparam logic [1:0] ENT_NONE = 2'd0;
    localparam logic [1:0] ENT_DEC  = 2'd1;
    localparam logic [1:0] ENT_HEX  = 2'd2;
    localparam logic [1:0] ENT_NAME = 2'd3;

    // parse mode flags
    typedef struct packed {
        logic asp;
        logic php;
        logic style;
        logic script;
        logic string1;
        logic string2;
        logic tag;
        logic comment1;
        logic comment;
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic [3:0]       skip;
        logic [CLS_W-1:0] tcls;
        logic [1:0]       ent;
        logic             at_ls;
        logic             line_pp;
    } t_state;

    function automatic t_chr asc(input logic [7:0] a);
        return t_chr'(a);
    endfunction

    function automatic logic is_digit(input t_chr c);
        return c >= asc("0") && c <= asc("9");
    endfunction

    function automatic logic is_alpha(input t_chr c);
        return (c >= asc("a") && c <= asc("z")) || (c >= asc("A") && c <= asc("Z"));
    endfunction

    function automatic logic is_alnum(input t_chr c);
        return is_digit(c) || is_alpha(c);
    endfunction

    function automatic logic is_xdigit(input t_chr c);
        return is_digit(c) || (c >= asc("a") && c <= asc("f"))
            || (c >= asc("A") && c <= asc("F"));
    endfunction

    function automatic t_chr to_lower(input t_chr c);
        return (c >= asc("A") && c <= asc("Z")) ? c + t_chr'(32) : c;
    endfunction

    // case-blind word match at offset, pattern right-aligned in pat
    function automatic logic word_at(input t_chr p [PEEK_N], input int off,
                                     input logic [63:0] pat, input int len);
        logic ok;
        t_chr c;
        ok = 1'b1;
        for (int j = 0; j < 8; j++) begin
            if (j < len) begin
                if (to_lower(p[off+j]) != asc(pat[8*(len-1-j) +: 8])) ok = 1'b0;
            end
        end
        c = p[off+len];
        return ok && c != asc("-") && c != asc("_") && !is_alnum(c);
    endfunction

endpackage

// ===== rtl/hscc_in_if.sv =====
`timescale 1ns / 1ps
interface hscc_in_if;
    logic                        valid;
    logic                        ready;
    logic [hscc_pkg::CHR_W-1:0]  ch;
    logic                        line_last;

    modport source (output valid, ch, line_last, input ready);
    modport sink   (input valid, ch, line_last, output ready);
endinterface

interface hscc_out_if;
    logic                        valid;
    logic                        ready;
    logic [hscc_pkg::CLS_W-1:0]  style_class;
    logic [hscc_pkg::CHR_W-1:0]  ch_out;
    logic                        line_last_out;

    modport source (output valid, style_class, ch_out, line_last_out, input ready);
    modport sink   (input valid, style_class, ch_out, line_last_out, output ready);
endinterface

// ===== rtl/html_source_char_classifier.sv =====
`timescale 1ns / 1ps
// Classifies HTML source one character per beat. A character is classified
// once the LOOKAHEAD-1 characters behind it have arrived and the result
// register can take it, and its result is offered from the cycle after that. A
// beat with line_last set drains the window at one result per cycle while the
// result side does not stall. Input ready stays low while a line drains, and
// while the window is full and the result side stalls. Otherwise one character
// goes in and one result comes out every cycle. One window shift register feeds
// one classifier and a result register, and that sets this rate.
module html_source_char_classifier #(
    parameter int LOOKAHEAD = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hscc_in_if.sink    i_in,
    hscc_out_if.source o_out
);
    import hscc_pkg::*;

    localparam int FW = $clog2(LOOKAHEAD + 1);
    localparam int IW = $clog2(LOOKAHEAD);

    t_chr             r_win [LOOKAHEAD];
    t_chr             n_win [LOOKAHEAD];
    logic [FW-1:0]    r_fill, n_fill;
    logic             r_flush, n_flush;
    t_state           r_st, n_st;
    logic             r_ov;
    logic [CLS_W-1:0] r_cls;
    t_chr             r_chr;
    logic             r_last;

    t_chr             peek [PEEK_N];
    logic [CLS_W-1:0] cls;
    t_state           cls_st;
    logic             emit, accept, flush_end;
    logic [FW-1:0]    wr_pos;

    // peek past the held characters reads NUL
    always_comb begin
        for (int k = 0; k < PEEK_N; k++) begin
            peek[k] = (FW'(k) < r_fill) ? r_win[k] : '0;
        end
    end

    hscc_classify u_cls (
        .i_peek (peek),
        .i_st   (r_st),
        .o_cls  (cls),
        .o_st   (cls_st)
    );

    // beat control
    assign emit = (!r_ov || o_out.ready)
               && (r_fill == FW'(LOOKAHEAD) || (r_flush && r_fill != '0));
    assign flush_end = emit && r_flush && r_fill == FW'(1);
    assign i_in.ready = !r_flush && (r_fill != FW'(LOOKAHEAD) || emit);
    assign accept = i_in.valid && i_in.ready;
    assign wr_pos = r_fill - FW'(emit);

    // window shift and append
    always_comb begin
        for (int i = 0; i < LOOKAHEAD; i++) begin
            if (accept && wr_pos[IW-1:0] == IW'(i)) begin
                n_win[i] = i_in.ch;
            end else if (emit && i < LOOKAHEAD - 1) begin
                n_win[i] = r_win[(i < LOOKAHEAD - 1) ? i + 1 : i];
            end else begin
                n_win[i] = r_win[i];
            end
        end
        n_fill  = r_fill - FW'(emit) + FW'(accept);
        n_flush = (r_flush && !flush_end) || (accept && i_in.line_last);
        n_st    = r_st;
        if (emit) begin
            n_st       = cls_st;
            n_st.at_ls = 1'b0;
        end
        if (flush_end) begin
            n_st.at_ls   = 1'b1;
            n_st.line_pp = 1'b0;
            n_st.skip    = 4'd0;
            n_st.ent     = ENT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LOOKAHEAD; i++) r_win[i] <= n_win[i];
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_flush <= 1'b0;
            r_st    <= '{mode: '0, skip: 4'd0, tcls: CLS_PLAIN, ent: ENT_NONE,
                         at_ls: 1'b1, line_pp: 1'b0};
        end else begin
            r_fill  <= n_fill;
            r_flush <= n_flush;
            r_st    <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (emit) begin
            r_cls  <= cls;
            r_chr  <= r_win[0];
            r_last <= flush_end;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.style_class   = r_cls;
    assign o_out.ch_out        = r_chr;
    assign o_out.line_last_out = r_last;
endmodule

// ===== rtl/hscc_classify.sv =====
`timescale 1ns / 1ps
module hscc_classify (
    input  hscc_pkg::t_chr                  i_peek [hscc_pkg::PEEK_N],
    input  hscc_pkg::t_state                i_st,
    output logic [hscc_pkg::CLS_W-1:0]      o_cls,
    output hscc_pkg::t_state                o_st
);
    import hscc_pkg::*;

    t_chr c, p1, p2, p3;
    logic m_php, m_script, m_style, m_end_script, m_end_style;
    assign c  = i_peek[0];
    assign p1 = i_peek[1];
    assign p2 = i_peek[2];
    assign p3 = i_peek[3];

    // word matches do not depend on mode, so work them out up front
    assign m_php        = word_at(i_peek, 0, 64'("<?php"), 5);
    assign m_script     = word_at(i_peek, 0, 64'("<script"), 7);
    assign m_style      = word_at(i_peek, 0, 64'("<style"), 6);
    assign m_end_script = word_at(i_peek, 1, 64'("/script"), 7);
    assign m_end_style  = word_at(i_peek, 1, 64'("/style"), 6);

    always_comb begin
        t_state s;
        logic   done;
        logic   more;
        logic   ent_go;
        t_chr   delim;
        s     = i_st;
        o_cls = CLS_PLAIN;
        done  = 1'b0;
        more  = 1'b0;
        ent_go = (c == asc("&")) && (p1 == asc("#") || is_alpha(p1));
        delim = i_st.mode.string1 ? asc("'") : asc("\"");

        // rest of a token already classified
        if (s.skip != 4'd0) begin
            s.skip = s.skip - 4'd1;
            o_cls  = s.tcls;
            done   = 1'b1;
        end
        // entity continuation
        if (!done && s.ent != ENT_NONE) begin
            case (s.ent)
                ENT_DEC: more = is_digit(c);
                ENT_HEX: more = is_xdigit(c);
                default: more = is_alnum(c);
            endcase
            if (more) begin
                o_cls = CLS_ENTITY;
                done  = 1'b1;
            end else begin
                s.ent = ENT_NONE;
                if (c == asc(";")) begin
                    o_cls = CLS_ENTITY;
                    done  = 1'b1;
                end
            end
        end
        if (!done && s.line_pp) begin
            o_cls = CLS_PREPROC;
            done  = 1'b1;
        end

        // mode walk; a region end may fall through to the next mode
        for (int it = 0; it < 4; it++) begin
            if (!done) begin
                done = 1'b1;
                if (s.mode.php) begin
                    o_cls = CLS_PHP;
                    if (c == asc("?") && p1 == asc(">")) begin
                        s.mode.php = 1'b0;
                        s.skip = 4'd1; s.tcls = CLS_PREPROC; o_cls = CLS_PREPROC;
                    end
                end else if (s.mode.asp) begin
                    o_cls = CLS_ASP;
                    if (c == asc("%") && p1 == asc(">")) begin
                        s.mode.asp = 1'b0;
                        s.skip = 4'd1; s.tcls = CLS_PREPROC; o_cls = CLS_PREPROC;
                    end
                end else if (s.mode.script && !s.mode.tag) begin
                    o_cls = CLS_SCRIPT;
                    if (c == asc("<") && m_end_script) begin
                        s.mode.script = 1'b0;
                        done = 1'b0;
                    end
                end else if (s.mode.style && !s.mode.tag) begin
                    o_cls = CLS_STYLE;
                    if (c == asc("<") && m_end_style) begin
                        s.mode.style = 1'b0;
                        done = 1'b0;
                    end
                end else if (s.mode.comment) begin
                    o_cls = CLS_COMMENT;
                    if (c == asc("-") && p1 == asc("-") && p2 == asc(">")) begin
                        s.mode.comment = 1'b0; s.mode.comment1 = 1'b0;
                        s.skip = 4'd2; s.tcls = CLS_COMMENT;
                    end
                end else if (s.mode.comment1) begin
                    o_cls = CLS_COMMENT;
                    if (c == asc(">")) s.mode.comment1 = 1'b0;
                end else if (s.mode.string2 || s.mode.string1) begin
                    o_cls = CLS_STRING;
                    if (ent_go) begin
                        o_cls = CLS_ENTITY;
                    end else if (c == delim) begin
                        s.mode.string2 = 1'b0; s.mode.string1 = 1'b0;
                    end else if (c == asc("<") && m_php) begin
                        s.mode.php = 1'b1;
                        s.skip = 4'd4; s.tcls = CLS_PREPROC; o_cls = CLS_PREPROC;
                    end else if (c == asc("<") && p1 == asc("%")) begin
                        s.mode.asp = 1'b1;
                        s.skip = 4'd1; s.tcls = CLS_PREPROC; o_cls = CLS_PREPROC;
                    end else if ((c == asc("?") || c == asc("%")) && p1 == asc(">")) begin
                        s.skip = 4'd1; s.tcls = CLS_STRING;
                    end else if (c == asc(">")) begin
                        s.mode.string2 = 1'b0; s.mode.string1 = 1'b0;
                        done = 1'b0;
                    end
                end else if (s.mode.tag) begin
                    o_cls = CLS_TAG;
                    if (ent_go) begin
                        o_cls = CLS_ENTITY;
                    end else if (c == asc("\"")) begin
                        s.mode.string2 = 1'b1; o_cls = CLS_STRING;
                    end else if (c == asc("'")) begin
                        s.mode.string1 = 1'b1; o_cls = CLS_STRING;
                    end else if (c == asc("/") && p1 == asc(">")) begin
                        s.mode = '0;
                        s.skip = 4'd1; s.tcls = CLS_TAG;
                    end else if (c == asc(">")) begin
                        s.mode.tag = 1'b0;
                    end
                end else begin
                    // plain text
                    o_cls = CLS_PLAIN;
                    if (c == asc("#") && s.at_ls) begin
                        s.line_pp = 1'b1; o_cls = CLS_PREPROC;
                    end else if (c == asc("<") && m_php) begin
                        s.mode.php = 1'b1;
                        s.skip = 4'd4; s.tcls = CLS_PREPROC; o_cls = CLS_PREPROC;
                    end else if (c == asc("<") && p1 == asc("%")) begin
                        s.mode.asp = 1'b1;
                        s.skip = 4'd1; s.tcls = CLS_PREPROC; o_cls = CLS_PREPROC;
                    end else if (c == asc("<") && (is_alpha(p1) || p1 == asc("!")
                                 || p1 == asc("/") || p1 == asc("?"))) begin
                        o_cls = CLS_TAG;
                        if (m_script) begin
                            s.mode.tag = 1'b1; s.mode.script = 1'b1;
                        end else if (m_style) begin
                            s.mode.tag = 1'b1; s.mode.style = 1'b1;
                        end else if (p1 == asc("!")) begin
                            o_cls = CLS_COMMENT; s.tcls = CLS_COMMENT;
                            if (p2 == asc("-") && p3 == asc("-")) begin
                                s.mode.comment = 1'b1; s.skip = 4'd3;
                            end else begin
                                s.mode.comment1 = 1'b1; s.skip = 4'd1;
                            end
                        end else begin
                            s.mode.tag = 1'b1;
                        end
                    end else if (ent_go) begin
                        o_cls = CLS_ENTITY;
                    end
                end
                // entity entry is shared by string, tag and plain text
                if (done && o_cls == CLS_ENTITY && ent_go) begin
                    s.tcls = CLS_ENTITY;
                    if (p1 == asc("#")) begin
                        if (p2 == asc("x")) begin
                            s.skip = 4'd2; s.ent = ENT_HEX;
                        end else begin
                            s.skip = 4'd1; s.ent = ENT_DEC;
                        end
                    end else begin
                        s.skip = 4'd1; s.ent = ENT_NAME;
                    end
                end
            end
        end
        o_st = s;
    end
endmodule

// ===== rtl/hscc_checker.sv =====
`timescale 1ns / 1ps
module hscc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_cls
);
    import hscc_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // classes stay within the defined codes
    a_cls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_cls <= CLS_STYLE)
        else $error("style class out of range");

    // a line end beat starts a drain, which blocks input
    a_line_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input taken during line drain");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind html_source_char_classifier hscc_checker u_hscc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.line_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_cls   (o_out.style_class)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import hscc_pkg::*;

    typedef struct {
        logic [CLS_W-1:0] cls;
        t_chr             ch;
        logic             last;
    } t_res;

    // Scoreboard: own copy of the classifier, queue of results still owed
    class char_class_board;
        t_res        owed_res[$];
        int          errors;
        t_mode       mode;
        t_chr        win [PEEK_N];
        int          fill;
        int          skip_n;
        logic [CLS_W-1:0] skip_cls;
        logic [1:0]  ent;
        bit          at_ls;
        bit          line_pp;

        function void clear();
            mode = '0;
            foreach (win[k]) win[k] = '0;
            fill = 0; skip_n = 0; skip_cls = CLS_PLAIN;
            ent = ENT_NONE; at_ls = 1; line_pp = 0;
            errors = 0;
        endfunction

        function t_chr peek(int k);
            return (k < fill && k < PEEK_N) ? win[k] : t_chr'(0);
        endfunction

        function bit dgt(t_chr c); return c >= "0" && c <= "9"; endfunction
        function bit alp(t_chr c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction
        function bit aln(t_chr c); return dgt(c) || alp(c); endfunction
        function bit xdg(t_chr c);
            return dgt(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        // case-blind keyword match, must not run on into a name character
        function bit kw_at(int off, string pat);
            t_chr c;
            for (int j = 0; j < pat.len(); j++) begin
                c = peek(off + j);
                if (c >= "A" && c <= "Z") c = c + 32;
                if (c != t_chr'(pat[j])) return 0;
            end
            c = peek(off + pat.len());
            return c != "-" && c != "_" && !aln(c);
        endfunction

        function bit ent_start(t_chr c, t_chr p1);
            return c == "&" && (p1 == "#" || alp(p1));
        endfunction

        function logic [CLS_W-1:0] open_entity(t_chr p1, t_chr p2);
            skip_cls = CLS_ENTITY;
            if (p1 == "#" && p2 == "x") begin
                skip_n = 2; ent = ENT_HEX;
            end else begin
                skip_n = 1; ent = (p1 == "#") ? ENT_DEC : ENT_NAME;
            end
            return CLS_ENTITY;
        endfunction

        function void skip_as(int n, logic [CLS_W-1:0] cls);
            skip_n = n; skip_cls = cls;
        endfunction

        function logic [CLS_W-1:0] class_of_head();
            t_chr c, p1, p2, p3, delim;
            bit more;
            c = peek(0); p1 = peek(1); p2 = peek(2); p3 = peek(3);
            if (skip_n > 0) begin
                skip_n--;
                return skip_cls;
            end
            if (ent != ENT_NONE) begin
                more = (ent == ENT_DEC) ? dgt(c) : (ent == ENT_HEX) ? xdg(c) : aln(c);
                if (more) return CLS_ENTITY;
                ent = ENT_NONE;
                if (c == ";") return CLS_ENTITY;
            end
            if (line_pp) return CLS_PREPROC;
            while (1) begin
                if (mode.php) begin
                    if (c == "?" && p1 == ">") begin
                        mode.php = 0; skip_as(1, CLS_PREPROC); return CLS_PREPROC;
                    end
                    return CLS_PHP;
                end
                if (mode.asp) begin
                    if (c == "%" && p1 == ">") begin
                        mode.asp = 0; skip_as(1, CLS_PREPROC); return CLS_PREPROC;
                    end
                    return CLS_ASP;
                end
                if (mode.script && !mode.tag) begin
                    if (c == "<" && kw_at(1, "/script")) begin
                        mode.script = 0; continue;
                    end
                    return CLS_SCRIPT;
                end
                if (mode.style && !mode.tag) begin
                    if (c == "<" && kw_at(1, "/style")) begin
                        mode.style = 0; continue;
                    end
                    return CLS_STYLE;
                end
                if (mode.comment) begin
                    if (c == "-" && p1 == "-" && p2 == ">") begin
                        mode.comment = 0; mode.comment1 = 0; skip_as(2, CLS_COMMENT);
                    end
                    return CLS_COMMENT;
                end
                if (mode.comment1) begin
                    if (c == ">") mode.comment1 = 0;
                    return CLS_COMMENT;
                end
                if (mode.string2 || mode.string1) begin
                    delim = mode.string1 ? t_chr'("'") : t_chr'("\"");
                    if (ent_start(c, p1)) return open_entity(p1, p2);
                    if (c == delim) begin
                        mode.string2 = 0; mode.string1 = 0; return CLS_STRING;
                    end
                    if (c == "<" && kw_at(0, "<?php")) begin
                        mode.php = 1; skip_as(4, CLS_PREPROC); return CLS_PREPROC;
                    end
                    if (c == "<" && p1 == "%") begin
                        mode.asp = 1; skip_as(1, CLS_PREPROC); return CLS_PREPROC;
                    end
                    if ((c == "?" || c == "%") && p1 == ">") begin
                        skip_as(1, CLS_STRING); return CLS_STRING;
                    end
                    if (c == ">") begin
                        mode.string2 = 0; mode.string1 = 0; continue;
                    end
                    return CLS_STRING;
                end
                if (mode.tag) begin
                    if (ent_start(c, p1)) return open_entity(p1, p2);
                    if (c == "\"") begin mode.string2 = 1; return CLS_STRING; end
                    if (c == "'") begin mode.string1 = 1; return CLS_STRING; end
                    if (c == "/" && p1 == ">") begin
                        mode = '0; skip_as(1, CLS_TAG); return CLS_TAG;
                    end
                    if (c == ">") mode.tag = 0;
                    return CLS_TAG;
                end
                // plain text
                if (c == "#" && at_ls) begin line_pp = 1; return CLS_PREPROC; end
                if (c == "<" && kw_at(0, "<?php")) begin
                    mode.php = 1; skip_as(4, CLS_PREPROC); return CLS_PREPROC;
                end
                if (c == "<" && p1 == "%") begin
                    mode.asp = 1; skip_as(1, CLS_PREPROC); return CLS_PREPROC;
                end
                if (c == "<" && (alp(p1) || p1 == "!" || p1 == "/" || p1 == "?")) begin
                    if (kw_at(0, "<script")) begin
                        mode.tag = 1; mode.script = 1; return CLS_TAG;
                    end
                    if (kw_at(0, "<style")) begin
                        mode.tag = 1; mode.style = 1; return CLS_TAG;
                    end
                    if (p1 == "!") begin
                        if (p2 == "-" && p3 == "-") begin
                            mode.comment = 1; skip_as(3, CLS_COMMENT);
                        end else begin
                            mode.comment1 = 1; skip_as(1, CLS_COMMENT);
                        end
                        return CLS_COMMENT;
                    end
                    mode.tag = 1;
                    return CLS_TAG;
                end
                if (ent_start(c, p1)) return open_entity(p1, p2);
                return CLS_PLAIN;
            end
            return CLS_PLAIN;
        endfunction

        function void pop_head(bit last);
            t_res r;
            r.cls  = class_of_head();
            at_ls  = 0;
            r.ch   = win[0];
            r.last = last;
            for (int j = 0; j < PEEK_N - 1; j++) win[j] = win[j+1];
            fill--;
            owed_res.push_back(r);
        endfunction

        // accepted input beat
        function void take_char(t_chr c, bit last);
            if (fill >= PEEK_N) fill = PEEK_N - 1;
            win[fill] = c;
            fill++;
            if (!last) begin
                if (fill >= PEEK_N) pop_head(0);
                return;
            end
            while (fill > 0) pop_head(fill == 1);
            at_ls = 1; line_pp = 0; skip_n = 0; ent = ENT_NONE;
        endfunction

        // accepted output beat
        function void check_result(logic [CLS_W-1:0] cls, t_chr ch, logic last);
            t_res r;
            if (owed_res.size() == 0) begin
                $error("unexpected result: class %0d ch %0h", cls, ch);
                errors++;
                return;
            end
            r = owed_res.pop_front();
            if (cls !== r.cls) begin
                $error("style_class: expected %0d, got %0d", r.cls, cls); errors++;
            end
            if (ch !== r.ch) begin
                $error("ch_out: expected %0h, got %0h", r.ch, ch); errors++;
            end
            if (last !== r.last) begin
                $error("line_last_out: expected %0b, got %0b", r.last, last); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    hscc_in_if  in_if ();
    hscc_out_if out_if ();
    char_class_board board;
    bit   no_idle;
    int   sent_chars;

    html_source_char_classifier u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // result side: random stalls, check at the rising edge
    initial begin
        int stall;
        stall = 0;
        out_if.ready = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready = 0;
                stall--;
            end else begin
                out_if.ready = 1;
                stall = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result(out_if.style_class, out_if.ch_out, out_if.line_last_out);
    end

    task automatic send_beat(t_chr c, bit last);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_if.valid = 0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid     = 1;
        in_if.ch        = c;
        in_if.line_last = last;
        do @(posedge i_clk); while (!in_if.ready);
        board.take_char(c, last);
        sent_chars++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int j = 0; j < s.len(); j++)
            send_beat(t_chr'(s[j]), j == s.len() - 1);
    endtask

    initial begin
        string frags [] = '{"<script>", "</script>", "<SCRIPT x>", "</ScRiPt>", "<style>",
                            "</STYLE>", "<?php", "<?PHP-", "?>", "<%", "%>", "<!--",
                            "-->", "<!x>", "&#x1f;", "&#12", "&amp;", "&a9", "\"", "'",
                            "#", "<a href='v'>", "<b c=\"d\">", "/>", "<", ">", "<?",
                            "<!-", "&", "&#", " ", "x"};
        t_chr line_q[$];
        int   n_tok;
        board = new();
        board.clear();
        in_if.valid = 0;
        in_if.ch = '0;
        in_if.line_last = 0;
        no_idle = 0;
        sent_chars = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: preprocess line, php, asp, comment, entities, extremes
        send_text("#<a");
        send_text("<?PhP ?>");
        send_text("<%a%>");
        send_text("<!--c-->");
        send_text("&#x1F;&#9;&amp");
        send_beat(t_chr'(0), 0);
        send_beat(t_chr'(21'h1FFFFF), 1);

        // random lines built from markup fragments plus noise
        while (sent_chars < 140) begin
            no_idle = ($urandom_range(0, 4) == 0);
            line_q.delete();
            n_tok = $urandom_range(1, 6);
            repeat (n_tok) begin
                int r;
                string f;
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    f = frags[$urandom_range(0, frags.size() - 1)];
                    for (int j = 0; j < f.len(); j++) line_q.push_back(t_chr'(f[j]));
                end else if (r < 9) begin
                    line_q.push_back(t_chr'($urandom_range(32, 126)));
                end else begin
                    line_q.push_back(t_chr'($urandom_range(0, 21'h1FFFFF)));
                end
            end
            foreach (line_q[k]) send_beat(line_q[k], k == line_q.size() - 1);
        end
        in_if.valid = 0;
        no_idle = 0;

        while (board.owed_res.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.owed_res.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== html_source_char_classifier.f =====
rtl/hscc_pkg.sv
rtl/hscc_in_if.sv
rtl/hscc_classify.sv
rtl/html_source_char_classifier.sv
rtl/hscc_checker.sv
tb/sv/tb_top.sv
